@@ rtl/adaptive_sample_convergence_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the adaptive sample convergence block
// Shared property forms, clocked on clock and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ADAPTIVE_SAMPLE_CONVERGENCE_DEFINES_SVH
`define ADAPTIVE_SAMPLE_CONVERGENCE_DEFINES_SVH

// same-cycle implication
`define ASC_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ASC_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/asc_pkg.sv @@
// ----------------------------------------------------------------------------
// asc_pkg
// Widths, register indexes, control word layout and microcode program of the
// adaptive sample convergence monitor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package asc_pkg;

   // default sample limits for the convergence tests
   localparam int MIN_TEST_DEFAULT = 32;
   localparam int MIN_FLAT_DEFAULT = 64;

   // field and datapath widths
   localparam int COLOR_W    = 24;
   localparam int THR_W      = 16;
   localparam int COUNT_W    = 16;
   localparam int SQ_W       = 64;
   localparam int LIMB_W     = 32;
   localparam int WIDE_W     = 4 * LIMB_W;
   localparam int PROD_W     = 2 * COLOR_W;
   localparam int DIV_BITS   = COLOR_W;
   localparam int PC_W       = 5;
   localparam int CTR_W      = 5;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;
   // confidence factor (1 - 4/n) offset
   localparam logic [COUNT_W-1:0] CONF_OFFSET = COUNT_W'(4);
   localparam logic [CTR_W-1:0]   DIV_LAST    = CTR_W'(DIV_BITS - 1);

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_ENABLE    = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] REG_THRESHOLD = CSR_INDEX_W'(1);
   localparam logic [CSR_INDEX_W-1:0] REG_NEAR_ZERO = CSR_INDEX_W'(2);

   // configuration reset values
   localparam logic             ENABLE_RESET    = 1'b1;
   localparam logic [THR_W-1:0] THRESHOLD_RESET = THR_W'(655);
   localparam logic [THR_W-1:0] NEAR_ZERO_RESET = THR_W'(1);

   // datapath operations
   typedef enum logic [3:0] {
      OP_NOP,
      OP_PREP,
      OP_DIV,
      OP_MEAN,
      OP_MAG2,
      OP_PROD,
      OP_ACC,
      OP_LOADL,
      OP_WMUL,
      OP_SAVEL,
      OP_CMP,
      OP_FLAT,
      OP_EMIT
   } op_type;

   // jump conditions; a taken jump goes to the target, else to the next step
   typedef enum logic [3:0] {
      COND_NEXT,
      COND_ALWAYS,
      COND_DISABLED,
      COND_DIV_LOOP,
      COND_LIMB_LOOP,
      COND_NO_TEST,
      COND_FLAT,
      COND_FEW,
      COND_OUT_BUSY
   } cond_type;

   // factor for a limb multiply pass
   typedef enum logic [1:0] {
      FAC_N,
      FAC_A,
      FAC_MEAN,
      FAC_NM1
   } fac_type;

   typedef logic [PC_W-1:0] pc_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      fac_type  fac;
      pc_type   target;
   } ctrl_word_type;

   // program addresses
   localparam pc_type P_PREP   = PC_W'(0);
   localparam pc_type P_DIV    = PC_W'(1);
   localparam pc_type P_MEAN   = PC_W'(2);
   localparam pc_type P_MAG2   = PC_W'(3);
   localparam pc_type P_PROD   = PC_W'(4);
   localparam pc_type P_ACC    = PC_W'(5);
   localparam pc_type P_SPLIT  = PC_W'(6);
   localparam pc_type P_LOADL  = PC_W'(7);
   localparam pc_type P_MUL_N  = PC_W'(8);
   localparam pc_type P_SAVEL  = PC_W'(9);
   localparam pc_type P_MUL_A  = PC_W'(10);
   localparam pc_type P_MUL_M1 = PC_W'(11);
   localparam pc_type P_MUL_M2 = PC_W'(12);
   localparam pc_type P_MUL_N1 = PC_W'(13);
   localparam pc_type P_CMP    = PC_W'(14);
   localparam pc_type P_FLAT   = PC_W'(15);
   localparam pc_type P_EMIT   = PC_W'(16);

   // microcode ROM
   function automatic ctrl_word_type ucode_rom(input pc_type pc);
      ctrl_word_type w;
      unique case (pc)
         P_PREP:   w = '{OP_PREP,  COND_DISABLED,  FAC_N,    P_EMIT};
         P_DIV:    w = '{OP_DIV,   COND_DIV_LOOP,  FAC_N,    P_DIV};
         P_MEAN:   w = '{OP_MEAN,  COND_NEXT,      FAC_N,    P_MAG2};
         P_MAG2:   w = '{OP_MAG2,  COND_NEXT,      FAC_N,    P_PROD};
         P_PROD:   w = '{OP_PROD,  COND_NEXT,      FAC_N,    P_ACC};
         P_ACC:    w = '{OP_ACC,   COND_NO_TEST,   FAC_N,    P_EMIT};
         P_SPLIT:  w = '{OP_NOP,   COND_FLAT,      FAC_N,    P_FLAT};
         P_LOADL:  w = '{OP_LOADL, COND_FEW,       FAC_N,    P_EMIT};
         P_MUL_N:  w = '{OP_WMUL,  COND_LIMB_LOOP, FAC_N,    P_MUL_N};
         P_SAVEL:  w = '{OP_SAVEL, COND_NEXT,      FAC_N,    P_MUL_A};
         P_MUL_A:  w = '{OP_WMUL,  COND_LIMB_LOOP, FAC_A,    P_MUL_A};
         P_MUL_M1: w = '{OP_WMUL,  COND_LIMB_LOOP, FAC_MEAN, P_MUL_M1};
         P_MUL_M2: w = '{OP_WMUL,  COND_LIMB_LOOP, FAC_MEAN, P_MUL_M2};
         P_MUL_N1: w = '{OP_WMUL,  COND_LIMB_LOOP, FAC_NM1,  P_MUL_N1};
         P_CMP:    w = '{OP_CMP,   COND_ALWAYS,    FAC_N,    P_EMIT};
         P_FLAT:   w = '{OP_FLAT,  COND_NEXT,      FAC_N,    P_EMIT};
         P_EMIT:   w = '{OP_EMIT,  COND_OUT_BUSY,  FAC_N,    P_EMIT};
         default:  w = '{OP_NOP,   COND_ALWAYS,    FAC_N,    P_EMIT};
      endcase
      return w;
   endfunction

endpackage

@@ rtl/adaptive_sample_convergence.sv @@
// ----------------------------------------------------------------------------
// adaptive_sample_convergence
// Per-pixel convergence monitor: Welford mean and spread of sample luminance
// with a relative standard error test and a flat-signal test at batch ends.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | words
//  req     | in        | req_valid/req_stall  | red, green, blue, pixel_start, batch_end
//  rsp     | out       | rsp_valid/rsp_stall  | converged, sample_count, running_mean
//  csr     | in        | csr_valid/csr_ready  | csr_index, csr_wdata
//
//  One word at a time runs through a microcoded datapath; a new word is taken
//  only after the result of the last one has gone to the output register.
//  A 24-step restoring divider and a 32-bit limb multiplier do the arithmetic.
//  Synchronous reset clears control and statistics and loads register defaults.
//  A waiting result holds in the output register; the program stalls at its
//  last step until the output register is free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "adaptive_sample_convergence_defines.svh"

module adaptive_sample_convergence
   import asc_pkg::*;
#(
   parameter int MIN_TEST_SAMPLES = MIN_TEST_DEFAULT,
   parameter int MIN_FLAT_SAMPLES = MIN_FLAT_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   // sample input
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [COLOR_W-1:0]     req_red,
   input  logic [COLOR_W-1:0]     req_green,
   input  logic [COLOR_W-1:0]     req_blue,
   input  logic                   req_pixel_start,
   input  logic                   req_batch_end,
   // result output
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_converged,
   output logic [COUNT_W-1:0]     rsp_sample_count,
   output logic [COLOR_W-1:0]     rsp_running_mean,
   // configuration writes
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam logic [COUNT_W-1:0] MIN_TEST_N = COUNT_W'(MIN_TEST_SAMPLES);
   localparam logic [COUNT_W-1:0] MIN_FLAT_N = COUNT_W'(MIN_FLAT_SAMPLES);

   // configuration registers
   logic             en_ff, en_in;
   logic [THR_W-1:0] thr_ff, thr_in;
   logic [THR_W-1:0] nz_ff, nz_in;

   // sequencer
   logic       busy_ff, busy_in;
   pc_type     pc_ff, pc_in;
   logic [CTR_W-1:0] ctr_ff, ctr_in;
   ctrl_word_type    ctrl;
   logic       cond_hit;
   logic       is_loop;
   logic       accept;
   logic       out_blocked;
   logic       emit;

   // pixel statistics
   logic [COLOR_W-1:0] mean_ff, mean_in;
   logic [SQ_W-1:0]    sq_ff, sq_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               done_ff, done_in;

   // per-word working registers
   logic [COLOR_W-1:0] lum_ff, lum_in;
   logic               bend_ff, bend_in;
   logic               up_ff, up_in;
   logic [COLOR_W-1:0] mag_ff, mag_in;
   logic [COLOR_W-1:0] mag2_ff, mag2_in;
   logic [COLOR_W-1:0] quo_ff, quo_in;
   logic [COUNT_W-1:0] rem_ff, rem_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [LIMB_W-1:0]  a_ff, a_in;
   logic [LIMB_W-1:0]  carry_ff, carry_in;
   logic [WIDE_W-1:0]  w_ff, w_in;
   logic [WIDE_W-1:0]  l_ff, l_in;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_conv_ff, rsp_conv_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic [COLOR_W-1:0] rsp_mean_ff, rsp_mean_in;

   // datapath helpers
   logic [COLOR_W-1:0]  lum_max;
   logic [COUNT_W-1:0]  count_base;
   logic [COLOR_W-1:0]  mag_now;
   logic [COUNT_W:0]    div_t;
   logic                div_ge;
   logic [COUNT_W:0]    div_r;
   logic [COLOR_W-1:0]  mean_next;
   logic [SQ_W:0]       sq_sum;
   logic [LIMB_W-1:0]   fac;
   logic [LIMB_W-1:0]   mul_x;
   logic [LIMB_W-1:0]   mul_y;
   logic [2*LIMB_W-1:0] mul_p;
   logic [2*LIMB_W-1:0] wmul_sum;
   logic                rel_gate;
   logic                flat_ok;

   // handshakes
   assign csr_ready   = 1'b1;
   assign req_stall   = busy_ff;
   assign accept      = req_valid && !busy_ff;
   assign out_blocked = rsp_valid_ff && rsp_stall;
   assign ctrl        = ucode_rom(pc_ff);
   assign emit        = busy_ff && (ctrl.op == OP_EMIT) && !out_blocked;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_converged    = rsp_conv_ff;
   assign rsp_sample_count = rsp_count_ff;
   assign rsp_running_mean = rsp_mean_ff;

   // configuration writes
   always_comb begin
      en_in  = en_ff;
      thr_in = thr_ff;
      nz_in  = nz_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_ENABLE:    en_in  = csr_wdata[0];
            REG_THRESHOLD: thr_in = csr_wdata[THR_W-1:0];
            REG_NEAR_ZERO: nz_in  = csr_wdata[THR_W-1:0];
            default:       ;
         endcase
      end
   end

   // luminance is the largest channel
   always_comb begin
      lum_max = req_red;
      if (req_green > lum_max) lum_max = req_green;
      if (req_blue > lum_max) lum_max = req_blue;
   end

   assign count_base = req_pixel_start ? '0 : count_ff;

   // restoring divider step, one quotient bit
   assign div_t  = {rem_ff, quo_ff[COLOR_W-1]};
   assign div_ge = div_t >= {1'b0, count_ff};
   assign div_r  = div_ge ? div_t - {1'b0, count_ff} : div_t;

   assign mag_now   = (lum_ff >= mean_ff) ? lum_ff - mean_ff : mean_ff - lum_ff;
   assign mean_next = up_ff ? mean_ff + quo_ff : mean_ff - quo_ff;
   assign sq_sum    = {1'b0, sq_ff} + {{(SQ_W + 1 - PROD_W){1'b0}}, prod_ff};

   assign rel_gate = mean_ff > {{(COLOR_W - THR_W){1'b0}}, nz_ff};
   assign flat_ok  = (sq_ff < {{(SQ_W - THR_W - 16){1'b0}}, nz_ff, 16'b0})
                     && (count_ff >= MIN_FLAT_N);

   // limb multiply factor
   always_comb begin
      unique case (ctrl.fac)
         FAC_N:    fac = {{(LIMB_W - COUNT_W){1'b0}}, count_ff};
         FAC_A:    fac = a_ff;
         FAC_MEAN: fac = {{(LIMB_W - COLOR_W){1'b0}}, mean_ff};
         FAC_NM1:  fac = {{(LIMB_W - COUNT_W){1'b0}}, count_ff - COUNT_W'(1)};
      endcase
   end

   // shared 32x32 multiplier
   always_comb begin
      mul_x = '0;
      mul_y = '0;
      unique case (ctrl.op)
         OP_PROD: begin
            mul_x = {{(LIMB_W - COLOR_W){1'b0}}, mag_ff};
            mul_y = {{(LIMB_W - COLOR_W){1'b0}}, mag2_ff};
         end
         OP_WMUL: begin
            mul_x = w_ff[LIMB_W-1:0];
            mul_y = fac;
         end
         OP_SAVEL: begin
            mul_x = {{(LIMB_W - THR_W){1'b0}}, thr_ff};
            mul_y = {{(LIMB_W - COUNT_W){1'b0}}, count_ff - CONF_OFFSET};
         end
         default: ;
      endcase
   end

   assign mul_p    = mul_x * mul_y;
   // first limb of a pass starts without carry
   assign wmul_sum = mul_p + {{LIMB_W{1'b0}},
                              (ctr_ff[1:0] == 2'b00) ? {LIMB_W{1'b0}} : carry_ff};

   // jump condition
   always_comb begin
      unique case (ctrl.cond)
         COND_NEXT:      cond_hit = 1'b0;
         COND_ALWAYS:    cond_hit = 1'b1;
         COND_DISABLED:  cond_hit = !en_ff;
         COND_DIV_LOOP:  cond_hit = ctr_ff != DIV_LAST;
         COND_LIMB_LOOP: cond_hit = ctr_ff[1:0] != 2'b11;
         COND_NO_TEST:   cond_hit = !(bend_ff && (count_ff >= MIN_TEST_N));
         COND_FLAT:      cond_hit = !rel_gate;
         COND_FEW:       cond_hit = count_ff <= CONF_OFFSET;
         COND_OUT_BUSY:  cond_hit = out_blocked;
         default:        cond_hit = 1'b0;
      endcase
   end

   assign is_loop = (ctrl.cond == COND_DIV_LOOP) || (ctrl.cond == COND_LIMB_LOOP);

   // step counter and loop counter
   always_comb begin
      busy_in = busy_ff;
      pc_in   = pc_ff;
      ctr_in  = ctr_ff;
      if (accept) begin
         busy_in = 1'b1;
         pc_in   = P_PREP;
         ctr_in  = '0;
      end else if (emit) begin
         busy_in = 1'b0;
         pc_in   = P_PREP;
         ctr_in  = '0;
      end else if (busy_ff) begin
         pc_in  = cond_hit ? ctrl.target : pc_ff + PC_W'(1);
         ctr_in = (is_loop && cond_hit) ? ctr_ff + CTR_W'(1) : '0;
      end
   end

   // datapath actions
   always_comb begin
      mean_in  = mean_ff;
      sq_in    = sq_ff;
      count_in = count_ff;
      done_in  = done_ff;
      lum_in   = lum_ff;
      bend_in  = bend_ff;
      up_in    = up_ff;
      mag_in   = mag_ff;
      mag2_in  = mag2_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      prod_in  = prod_ff;
      a_in     = a_ff;
      carry_in = carry_ff;
      w_in     = w_ff;
      l_in     = l_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_conv_in  = rsp_conv_ff;
      rsp_count_in = rsp_count_ff;
      rsp_mean_in  = rsp_mean_ff;

      if (accept) begin
         // pixel start clears, then the count steps when enabled and not saturated
         lum_in  = lum_max;
         bend_in = req_batch_end;
         if (req_pixel_start) begin
            mean_in = '0;
            sq_in   = '0;
            done_in = 1'b0;
         end
         count_in = (en_ff && (count_base != COUNT_MAX)) ? count_base + COUNT_W'(1)
                                                         : count_base;
      end else if (busy_ff) begin
         unique case (ctrl.op)
            OP_PREP: begin
               up_in  = lum_ff >= mean_ff;
               mag_in = mag_now;
               quo_in = mag_now;
               rem_in = '0;
            end
            OP_DIV: begin
               quo_in = {quo_ff[COLOR_W-2:0], div_ge};
               rem_in = div_r[COUNT_W-1:0];
            end
            OP_MEAN: mean_in = mean_next;
            OP_MAG2: mag2_in = up_ff ? lum_ff - mean_ff : mean_ff - lum_ff;
            OP_PROD: prod_in = mul_p[PROD_W-1:0];
            OP_ACC:  sq_in   = sq_sum[SQ_W] ? {SQ_W{1'b1}} : sq_sum[SQ_W-1:0];
            OP_LOADL: w_in = {{LIMB_W{1'b0}}, sq_ff, {LIMB_W{1'b0}}};
            OP_WMUL: begin
               // rotate limbs so the next limb sits at the bottom
               w_in     = {wmul_sum[LIMB_W-1:0], w_ff[WIDE_W-1:LIMB_W]};
               carry_in = wmul_sum[2*LIMB_W-1:LIMB_W];
            end
            OP_SAVEL: begin
               l_in = w_ff;
               a_in = mul_p[LIMB_W-1:0];
               w_in = {{(WIDE_W - LIMB_W){1'b0}}, mul_p[LIMB_W-1:0]};
            end
            OP_CMP: if (l_ff < w_ff) done_in = 1'b1;
            OP_FLAT: if (flat_ok) done_in = 1'b1;
            OP_EMIT: begin
               if (!out_blocked) begin
                  rsp_valid_in = 1'b1;
                  rsp_conv_in  = done_ff;
                  rsp_count_in = count_ff;
                  rsp_mean_in  = mean_ff;
               end
            end
            default: ;
         endcase
      end
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         en_ff        <= ENABLE_RESET;
         thr_ff       <= THRESHOLD_RESET;
         nz_ff        <= NEAR_ZERO_RESET;
         busy_ff      <= 1'b0;
         pc_ff        <= P_PREP;
         ctr_ff       <= '0;
         mean_ff      <= '0;
         sq_ff        <= '0;
         count_ff     <= '0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         en_ff        <= en_in;
         thr_ff       <= thr_in;
         nz_ff        <= nz_in;
         busy_ff      <= busy_in;
         pc_ff        <= pc_in;
         ctr_ff       <= ctr_in;
         mean_ff      <= mean_in;
         sq_ff        <= sq_in;
         count_ff     <= count_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working and payload registers
   always_ff @(posedge clock) begin
      lum_ff       <= lum_in;
      bend_ff      <= bend_in;
      up_ff        <= up_in;
      mag_ff       <= mag_in;
      mag2_ff      <= mag2_in;
      quo_ff       <= quo_in;
      rem_ff       <= rem_in;
      prod_ff      <= prod_in;
      a_ff         <= a_in;
      carry_ff     <= carry_in;
      w_ff         <= w_in;
      l_ff         <= l_in;
      rsp_conv_ff  <= rsp_conv_in;
      rsp_count_ff <= rsp_count_in;
      rsp_mean_ff  <= rsp_mean_in;
   end

   // checks
   `ASC_ASSERT_NXT(a_accept_starts, accept, busy_ff && pc_ff == P_PREP, "word not started")
   `ASC_ASSERT_IMP(a_rsp_from_emit, $rose(rsp_valid), $fell(busy_ff), "stray result")
   `ASC_ASSERT_IMP(a_div_rem_bound, busy_ff && ctrl.op == OP_DIV, rem_ff < count_ff, "rem range")

endmodule
